### src/mctc_pkg.sv
// ============================================================================
// mctc_pkg
// Shared widths, reset values and types of the charge-time counter.
// ============================================================================
package mctc_pkg;

    localparam int CHANNELS_DEF = 12;
    localparam int SENSE_W      = 12;
    localparam int COUNT_W      = 16;
    localparam int CHAN_W       = 4;
    localparam int CYC_W        = 8;

    localparam logic [CYC_W-1:0] CYC_RESET = 8'd255;

    // Outcome of one accepted sample, passed from the control to the output stage.
    typedef struct packed {
        logic drive_high;
        logic report;
    } mctc_evt_t;

endpackage

### src/mctc_lane.sv
// ============================================================================
// mctc_lane
// One channel's counter, incremented while its pin has not yet crossed.
// ============================================================================
module mctc_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          level,
    input  logic                          phase_high,
    input  logic                          accept,
    input  logic                          clear,
    output logic                          active,
    output logic [mctc_pkg::COUNT_W-1:0]  count
);

    logic [mctc_pkg::COUNT_W-1:0] count_reg;
    logic [mctc_pkg::COUNT_W-1:0] count_next;

    assign active = phase_high ? ~level : level;
    assign count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (clear)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + {{(mctc_pkg::COUNT_W-1){1'b0}}, active};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

### src/mctc_ctrl.sv
// ============================================================================
// mctc_ctrl
// Drive phase, cycle count and the report decision merged from all lanes.
// ============================================================================
module mctc_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         all_idle,
    input  logic                         cfg_write,
    input  logic [mctc_pkg::CYC_W-1:0]   cfg_data,
    output logic                         phase_high,
    output mctc_pkg::mctc_evt_t          evt
);

    logic                        drive_reg;
    logic                        drive_next;
    logic [mctc_pkg::CYC_W-1:0]  cycles_done_reg;
    logic [mctc_pkg::CYC_W-1:0]  cycles_done_next;
    logic [mctc_pkg::CYC_W-1:0]  target_reg;
    logic [mctc_pkg::CYC_W-1:0]  target_eff;
    logic [mctc_pkg::CYC_W:0]    done_plus;
    logic                        cycle_end;
    logic                        report;

    assign phase_high = drive_reg;
    assign target_eff = (target_reg == '0) ? {{(mctc_pkg::CYC_W-1){1'b0}}, 1'b1} : target_reg;
    assign done_plus  = {1'b0, cycles_done_reg} + {{mctc_pkg::CYC_W{1'b0}}, 1'b1};
    assign cycle_end  = drive_reg && all_idle;
    assign report     = cycle_end && (done_plus >= {1'b0, target_eff});
    assign drive_next = all_idle ? ~drive_reg : drive_reg;

    assign evt.drive_high = drive_next;
    assign evt.report     = report;

    always_comb
    begin
        cycles_done_next = cycles_done_reg;
        if (cycle_end)
        begin
            cycles_done_next = report ? '0 : done_plus[mctc_pkg::CYC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg       <= 1'b0;
            cycles_done_reg <= '0;
            target_reg      <= mctc_pkg::CYC_RESET;
        end
        else
        begin
            if (accept)
            begin
                drive_reg       <= drive_next;
                cycles_done_reg <= cycles_done_next;
            end
            if (cfg_write)
            begin
                target_reg <= cfg_data;
            end
        end
    end

endmodule

### src/mctc_report.sv
// ============================================================================
// mctc_report
// Output word register and report serializer for the captured counts.
// ============================================================================
module mctc_report #(
    parameter int CHANNELS = mctc_pkg::CHANNELS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  mctc_pkg::mctc_evt_t                         evt,
    input  logic [CHANNELS-1:0][mctc_pkg::COUNT_W-1:0]  counts,
    input  logic                                        out_stall,
    output logic                                        busy,
    output logic                                        out_valid,
    output logic                                        drive_high,
    output logic                                        report,
    output logic [mctc_pkg::CHAN_W-1:0]                 channel,
    output logic [mctc_pkg::COUNT_W-1:0]                count,
    output logic                                        last
);

    localparam logic [mctc_pkg::CHAN_W-1:0] LAST_CH = mctc_pkg::CHAN_W'(CHANNELS - 1);

    logic                                        valid_reg;
    logic                                        drive_reg;
    logic                                        report_reg;
    logic [mctc_pkg::CHAN_W-1:0]                 chan_reg;
    logic [CHANNELS-1:0][mctc_pkg::COUNT_W-1:0]  buf_reg;
    logic                                        pop;

    assign last       = !report_reg || (chan_reg == LAST_CH);
    assign pop        = valid_reg && !out_stall;
    assign busy       = valid_reg && !(pop && last);
    assign out_valid  = valid_reg;
    assign drive_high = drive_reg;
    assign report     = report_reg;
    assign channel    = report_reg ? chan_reg : '0;
    assign count      = report_reg ? buf_reg[0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            report_reg <= 1'b0;
            chan_reg   <= '0;
            drive_reg  <= 1'b0;
        end
        else if (load)
        begin
            valid_reg  <= 1'b1;
            report_reg <= evt.report;
            chan_reg   <= '0;
            drive_reg  <= evt.drive_high;
        end
        else if (pop)
        begin
            if (last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                chan_reg <= chan_reg + {{(mctc_pkg::CHAN_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && evt.report)
        begin
            buf_reg <= counts;
        end
        else if (pop && !last)
        begin
            for (int i = 0; i < CHANNELS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

endmodule

### src/multichannel_charge_time_counter_top.sv
// ============================================================================
// multichannel_charge_time_counter_top
// Charge-time capacitive sensing over several channels sharing one drive pin.
// ============================================================================
// The block takes one sample of the sense pins per clock while in_stall is low
// and answers each sample with one word giving the new drive level. When the
// configured number of discharge and charge cycles is complete, the sample
// instead yields one word per channel, channel 0 first, with last set on the
// final word, and the counters clear. Those words leave one per clock through a
// shift register while out_stall is low, so a reporting sample holds the input
// until its final word is taken. The configuration port is always ready.
module multichannel_charge_time_counter_top #(
    parameter int CHANNELS = mctc_pkg::CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [mctc_pkg::SENSE_W-1:0]       sense_levels,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               drive_high,
    output logic                               report,
    output logic [mctc_pkg::CHAN_W-1:0]        channel,
    output logic [mctc_pkg::COUNT_W-1:0]       count,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mctc_pkg::CYC_W-1:0]         cycles_per_report
);

    logic                                        accept;
    logic                                        phase_high;
    logic [CHANNELS-1:0]                         active;
    logic [CHANNELS-1:0][mctc_pkg::COUNT_W-1:0]  counts;
    mctc_pkg::mctc_evt_t                         evt;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        logic level;
        if (g < mctc_pkg::SENSE_W)
        begin : g_pin
            assign level = sense_levels[g];
        end
        else
        begin : g_nopin
            assign level = 1'b0;
        end

        mctc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .level      (level),
            .phase_high (phase_high),
            .accept     (accept),
            .clear      (evt.report),
            .active     (active[g]),
            .count      (counts[g])
        );
    end

    mctc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .all_idle   (active == '0),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cycles_per_report),
        .phase_high (phase_high),
        .evt        (evt)
    );

    mctc_report #(
        .CHANNELS (CHANNELS)
    ) u_report (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .evt        (evt),
        .counts     (counts),
        .out_stall  (out_stall),
        .busy       (in_stall),
        .out_valid  (out_valid),
        .drive_high (drive_high),
        .report     (report),
        .channel    (channel),
        .count      (count),
        .last       (last)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the multichannel charge-time counter.
// ============================================================================
// A short table of directed samples comes first. It covers the field extremes,
// both phase changes, reports under several report intervals, a zero interval,
// and an interval lowered below the cycles already done. Random discharge and
// charge sequences with noise follow. Each output word is checked against an
// in-bench prediction. Both handshakes idle at random rates.
module tb_top;

    localparam int CHANNELS      = mctc_pkg::CHANNELS_DEF;
    localparam int DIRECTED_ROWS = 25;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic                         drive_high;
        logic                         report;
        logic [mctc_pkg::CHAN_W-1:0]  channel;
        logic [mctc_pkg::COUNT_W-1:0] count;
        logic                         last;
    } charge_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [mctc_pkg::SENSE_W-1:0] val;
        logic                         typed;
        logic                         typed_drive;
    } row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [mctc_pkg::SENSE_W-1:0] sense_levels = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         drive_high;
    logic                         report;
    logic [mctc_pkg::CHAN_W-1:0]  channel;
    logic [mctc_pkg::COUNT_W-1:0] count;
    logic                         last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [mctc_pkg::CYC_W-1:0]   cycles_per_report = '0;

    logic [mctc_pkg::COUNT_W-1:0] chan_count [CHANNELS];
    logic                         drive_is_high;
    logic [mctc_pkg::CYC_W-1:0]   cycles_seen;
    logic [mctc_pkg::CYC_W-1:0]   report_every;

    charge_word_t charge_words [$];
    row_t         directed_rows [DIRECTED_ROWS];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    multichannel_charge_time_counter_top #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sense_levels(sense_levels),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .drive_high(drive_high),
        .report(report),
        .channel(channel),
        .count(count),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cycles_per_report(cycles_per_report)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        charge_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (charge_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time,
                         {drive_high, report, channel, count, last});
                mismatches++;
            end
            else
            begin
                want = charge_words.pop_front();
                flag_field("drive_high", want.drive_high, drive_high);
                flag_field("report", want.report, report);
                flag_field("channel", want.channel, channel);
                flag_field("count", want.count, count);
                flag_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic step_charge_counter(input logic [mctc_pkg::SENSE_W-1:0] lv);
        logic [CHANNELS-1:0]        active;
        logic                       cycle_end;
        logic                       reporting;
        logic [mctc_pkg::CYC_W-1:0] target;
        charge_word_t               w;
        active = drive_is_high ? ~lv[CHANNELS-1:0] : lv[CHANNELS-1:0];
        for (int i = 0; i < CHANNELS; i++)
            chan_count[i] = chan_count[i] + mctc_pkg::COUNT_W'(active[i]);
        cycle_end = 1'b0;
        reporting = 1'b0;
        if (active == '0)
        begin
            cycle_end = drive_is_high;
            drive_is_high = !drive_is_high;
        end
        if (cycle_end)
        begin
            target = (report_every == '0) ? 8'd1 : report_every;
            if ({1'b0, cycles_seen} + 9'd1 >= {1'b0, target})
            begin
                reporting = 1'b1;
                cycles_seen = '0;
            end
            else
                cycles_seen = cycles_seen + 8'd1;
        end
        if (reporting)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                w = '{drive_is_high, 1'b1, mctc_pkg::CHAN_W'(i), chan_count[i],
                      (i == CHANNELS - 1)};
                charge_words.push_back(w);
                chan_count[i] = '0;
            end
        end
        else
        begin
            w = '{drive_is_high, 1'b0, '0, '0, 1'b1};
            charge_words.push_back(w);
        end
    endtask

    // The prediction is queued before the word is offered, so it is always
    // waiting when the matching output appears.
    task automatic send_sample(input logic [mctc_pkg::SENSE_W-1:0] s, input logic typed,
                               input logic typed_drive);
        charge_word_t w;
        step_charge_counter(s);
        if (typed)
        begin
            void'(charge_words.pop_back());
            w = '{typed_drive, 1'b0, '0, '0, 1'b1};
            charge_words.push_back(w);
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sense_levels <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [mctc_pkg::CYC_W-1:0] v);
        in_valid <= 1'b0;
        while (charge_words.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cycles_per_report <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        report_every = v;
    endtask

    // Well-formed phases let each pin settle after its own hold time, so the last
    // sample flips the drive unless a bit flip hits it; the rest is plain noise.
    task automatic run_random(input int n_items, input int cfg_lo, input int cfg_hi);
        int                           sent;
        int                           longest;
        int                           hold [CHANNELS];
        logic                         high_phase;
        logic [mctc_pkg::SENSE_W-1:0] s;
        write_config(mctc_pkg::CYC_W'($urandom_range(cfg_hi, cfg_lo)));
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                longest = 0;
                high_phase = drive_is_high;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    hold[i] = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(5);
                    if (hold[i] > longest)
                        longest = hold[i];
                end
                for (int t = 0; t <= longest; t++)
                begin
                    for (int i = 0; i < CHANNELS; i++)
                        s[i] = (t < hold[i]) ^ high_phase;
                    if ($urandom_range(19) == 0)
                        s[$urandom_range(CHANNELS - 1)] ^= 1'b1;
                    send_sample(s, 1'b0, 1'b0);
                    sent++;
                end
            end
            else
            begin
                send_sample(mctc_pkg::SENSE_W'($urandom_range(4095)), 1'b0, 1'b0);
                sent++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
            chan_count[i] = '0;
        drive_is_high = 1'b0;
        cycles_seen = '0;
        report_every = mctc_pkg::CYC_RESET;

        directed_rows = '{
            '{ROW_CONFIG, 12'd2,   1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b1, 1'b1},
            '{ROW_SAMPLE, 12'h000, 1'b1, 1'b1},
            '{ROW_SAMPLE, 12'hFFF, 1'b1, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b1, 1'b0},
            '{ROW_SAMPLE, 12'h555, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b1, 1'b1},
            '{ROW_SAMPLE, 12'hAAA, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_CONFIG, 12'd0,   1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_CONFIG, 12'd5,   1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_CONFIG, 12'd1,   1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h123, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h000, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'hFFF, 1'b0, 1'b0},
            '{ROW_CONFIG, 12'd255, 1'b0, 1'b0},
            '{ROW_SAMPLE, 12'h800, 1'b0, 1'b0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 66;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
                write_config(directed_rows[r].val[mctc_pkg::CYC_W-1:0]);
            else
                send_sample(directed_rows[r].val, directed_rows[r].typed,
                            directed_rows[r].typed_drive);
        end
        run_random(40, 1, 3);
        run_random(40, 0, 2);

        send_idle_pct = 66;
        recv_idle_pct = 37;
        run_random(35, 2, 6);
        run_random(35, 1, 4);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(70, 0, 4);

        in_valid <= 1'b0;
        while (charge_words.size() != 0)
            @(posedge clk);
        repeat (CHANNELS + 8) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/mctc_pkg.sv
src/mctc_lane.sv
src/mctc_ctrl.sv
src/mctc_report.sv
src/multichannel_charge_time_counter_top.sv
verif/tb_top.sv
